@@ hw/rtl/rrvg_pkg.sv @@
// Shared types, constants and small tables for the rotated rectangle vertex generator.
// No dependencies; imported by every module of the block.
package rrvg_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int TRIG_BITS   = 16;
  localparam int TRIG_SHIFT  = TRIG_BITS - 1;
  localparam int ANGLE_WIDTH = 16;
  localparam int RGBA_WIDTH  = 32;
  localparam int OFS_WIDTH   = COORD_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [TRIG_BITS-1:0]   trig_t;
  typedef logic signed [OFS_WIDTH-1:0]   ofs_t;
  typedef logic [2:0]                    vidx_t;
  typedef logic [1:0]                    corner_t;
  typedef logic [3:0]                    step_t;

  localparam vidx_t LAST_IDX = 3'd5;

  // series step codes: 0..3 sine terms, 4..8 cosine terms, one for the angle scale
  localparam step_t STEP_SIN_LAST  = 4'd3;
  localparam step_t STEP_COS_FIRST = 4'd4;
  localparam step_t STEP_LAST      = 4'd8;
  localparam step_t STEP_ANG       = 4'd9;

  typedef struct packed {
    coord_t                        rect_x;
    coord_t                        rect_y;
    coord_t                        rect_width;
    coord_t                        rect_height;
    coord_t                        pivot_x;
    coord_t                        pivot_y;
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic [RGBA_WIDTH-1:0]         fill_rgba;
  } in_item_t;

  typedef struct packed {
    coord_t                vert_x;
    coord_t                vert_y;
    logic [RGBA_WIDTH-1:0] vert_rgba;
    vidx_t                 vert_index;
    logic                  is_last;
  } out_item_t;

  typedef struct packed {
    coord_t                  rx;
    coord_t                  ry;
    coord_t                  w;
    coord_t                  h;
    logic signed [COORD_WIDTH:0] dx;
    logic signed [COORD_WIDTH:0] dy;
    logic [RGBA_WIDTH-1:0]   rgba;
    logic                    rot;
    trig_t                   s;
    trig_t                   c;
  } q_entry_t;

  typedef struct packed {
    logic [6:0]  d;
    logic [31:0] m;   // floor(2^32 / d)
  } div_sel_t;

  function automatic div_sel_t div_sel(input step_t step);
    div_sel_t r;
    case (step)
      4'd0:     r = '{d: 7'd6,  m: 32'd715827882};
      4'd1:     r = '{d: 7'd20, m: 32'd214748364};
      4'd2:     r = '{d: 7'd42, m: 32'd102261126};
      4'd3:     r = '{d: 7'd72, m: 32'd59652323};
      4'd4:     r = '{d: 7'd2,  m: 32'd2147483648};
      4'd5:     r = '{d: 7'd12, m: 32'd357913941};
      4'd6:     r = '{d: 7'd30, m: 32'd143165576};
      4'd7:     r = '{d: 7'd56, m: 32'd76695844};
      4'd8:     r = '{d: 7'd90, m: 32'd47721858};
      4'd9:     r = '{d: 7'd45, m: 32'd95443717};
      default:  r = '{d: 7'd1,  m: 32'd0};
    endcase
    return r;
  endfunction

  // emission order TL, BL, TR, TR, BL, BR; corner bit0 adds width, bit1 adds height
  function automatic corner_t corner_of(input vidx_t idx);
    corner_t k;
    case (idx)
      3'd0:    k = 2'd0;
      3'd1:    k = 2'd2;
      3'd2:    k = 2'd1;
      3'd3:    k = 2'd1;
      3'd4:    k = 2'd2;
      3'd5:    k = 2'd3;
      default: k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/rotated_rect_vertex_gen_core.sv @@
// Top level of the rotated rectangle vertex generator: front end, queue, back end.
// Depends on rrvg_pkg, rrvg_front, rrvg_queue and rrvg_back.
//
//   channel  ports                   handshake
//   input    start, busy, in_item    word taken at edge with start && !busy
//   output   out_valid, out_item     one word per cycle while out_valid, no stall
//
// Unrotated rectangle (angle field zero): the rate is set by the back end emitting
// one vertex per cycle; the front end passes only through its idle and push states.
// Rotated rectangle: the rate is set by the front-end sine/cosine sequencer (angle
// scale, square, nine series terms, each with a reciprocal divide and correction).
// Six vertices then follow, one per cycle, each going from the queue head through the
// back-end stage-1 and output registers. The two-entry queue lets the
// front end start the next rectangle while the back end still emits the last.
// Reset (rst_n low, synchronous) empties the queue and idles both ends.
// The receiver cannot stall: out_valid words must be taken as they come.
module rotated_rect_vertex_gen_core import rrvg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  logic     push, pop, q_full, q_empty;
  q_entry_t push_data, head;

  rrvg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rrvg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  rrvg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ hw/rtl/rrvg_front.sv @@
// Front end: accepts rectangles, reduces the angle and runs the sine/cosine sequencer.
// Depends on rrvg_pkg; feeds rrvg_queue.
module rrvg_front import rrvg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  output logic     push,
  output q_entry_t push_data,
  input  logic     q_full
);

  typedef enum logic [3:0] {
    F_IDLE, F_T0, F_DA, F_DB, F_T2, F_MUL, F_FIN, F_PUSH
  } fstate_t;

  localparam logic signed [17:0] TURN    = 18'sd23040;
  localparam logic [14:0]        Q1      = 15'd5760;
  localparam logic [14:0]        Q2      = 15'd11520;
  localparam logic [14:0]        Q3      = 15'd17280;
  localparam logic [12:0]        EIGHTH  = 13'd2880;
  localparam logic [12:0]        QUARTER = 13'd5760;
  localparam logic [30:0]        ONE_Q30 = 31'h4000_0000;
  localparam int                 SH      = 30 - TRIG_SHIFT;
  localparam logic signed [31:0] TOP     = (32'sd1 <<< TRIG_SHIFT) - 32'sd1;

  fstate_t state_r;
  in_item_t item_r;
  logic        rot_r, swap_r;
  logic [1:0]  quad_r;
  logic [11:0] fo_r;
  logic [30:0] p_r, div_x_r, q0_r, term_r;
  logic [29:0] t_r, t2_r;
  step_t       step_r;
  logic signed [31:0] sin_acc_r, cos_acc_r;
  trig_t       s_r, c_r;

  // angle reduction
  logic signed [17:0] a0, a1, a2;
  logic [14:0] r_nxt;
  logic [1:0]  quad_nxt;
  logic [12:0] f_nxt;
  logic        swap_nxt;
  logic [11:0] fo_nxt;

  always_comb begin
    a0 = 18'(in_item.angle);
    a1 = (a0 < 0) ? a0 + TURN : a0;
    a2 = (a1 < 0) ? a1 + TURN : a1;
    r_nxt = (a2 >= TURN) ? 15'(a2 - TURN) : 15'(a2);
    if (r_nxt >= Q3) begin
      quad_nxt = 2'd3; f_nxt = 13'(r_nxt - Q3);
    end else if (r_nxt >= Q2) begin
      quad_nxt = 2'd2; f_nxt = 13'(r_nxt - Q2);
    end else if (r_nxt >= Q1) begin
      quad_nxt = 2'd1; f_nxt = 13'(r_nxt - Q1);
    end else begin
      quad_nxt = 2'd0; f_nxt = 13'(r_nxt);
    end
    swap_nxt = (f_nxt > EIGHTH);
    fo_nxt   = swap_nxt ? 12'(QUARTER - f_nxt) : 12'(f_nxt);
  end

  // datapath pieces shared by the sequencer states
  div_sel_t    sel;
  logic [62:0] dprod;
  logic [37:0] drem;
  logic [30:0] q_nxt, p_nxt, mul_nxt, mterm;
  logic [25:0] y_sum;
  logic [30:0] tsum;
  logic [59:0] tsq;
  logic [60:0] mprod;

  always_comb begin
    sel     = div_sel(step_r);
    dprod   = 63'(div_x_r) * 63'(sel.m);
    drem    = 38'(div_x_r) - 38'(q0_r) * 38'(sel.d);
    q_nxt   = q0_r + 31'(drem >= 38'(sel.d));
    p_nxt   = 31'(fo_r) * 31'd292817;
    y_sum   = 26'(fo_r) * 26'd7586 + 26'd5760;
    tsum    = p_r + q_nxt;
    tsq     = 60'(t_r) * 60'(t_r);
    mterm   = (step_r == STEP_COS_FIRST) ? ONE_Q30 : term_r;
    mprod   = 61'(mterm) * 61'(t2_r);
    mul_nxt = mprod[60:30];
  end

  function automatic trig_t to_trig(input logic signed [31:0] acc);
    logic signed [31:0] rs;
    rs = (acc + (32'sd1 <<< (SH - 1))) >>> SH;
    return (rs > TOP) ? TOP[TRIG_BITS-1:0] : rs[TRIG_BITS-1:0];
  endfunction

  trig_t bs, bc, s_nxt, c_nxt;
  always_comb begin
    bs = swap_r ? to_trig(cos_acc_r) : to_trig(sin_acc_r);
    bc = swap_r ? to_trig(sin_acc_r) : to_trig(cos_acc_r);
    case (quad_r)
      2'd0:    begin s_nxt = bs;  c_nxt = bc;  end
      2'd1:    begin s_nxt = bc;  c_nxt = -bs; end
      2'd2:    begin s_nxt = -bs; c_nxt = -bc; end
      default: begin s_nxt = -bc; c_nxt = bs;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: if (start) begin
          item_r  <= in_item;
          quad_r  <= quad_nxt;
          swap_r  <= swap_nxt;
          fo_r    <= fo_nxt;
          rot_r   <= (in_item.angle != '0);
          state_r <= (in_item.angle != '0) ? F_T0 : F_PUSH;
        end
        F_T0: begin
          p_r     <= p_nxt;
          div_x_r <= 31'(y_sum[25:8]);
          step_r  <= STEP_ANG;
          state_r <= F_DA;
        end
        F_DA: begin
          q0_r    <= dprod[62:32];
          state_r <= F_DB;
        end
        F_DB: begin
          if (step_r == STEP_ANG) begin
            t_r     <= tsum[29:0];
            state_r <= F_T2;
          end else begin
            term_r <= q_nxt;
            if (step_r <= STEP_SIN_LAST)
              sin_acc_r <= step_r[0] ? sin_acc_r + $signed({1'b0, q_nxt})
                                     : sin_acc_r - $signed({1'b0, q_nxt});
            else
              cos_acc_r <= step_r[0] ? cos_acc_r + $signed({1'b0, q_nxt})
                                     : cos_acc_r - $signed({1'b0, q_nxt});
            if (step_r == STEP_LAST) begin
              state_r <= F_FIN;
            end else begin
              step_r  <= step_r + 4'd1;
              state_r <= F_MUL;
            end
          end
        end
        F_T2: begin
          t2_r      <= tsq[59:30];
          term_r    <= {1'b0, t_r};
          sin_acc_r <= 32'(t_r);
          cos_acc_r <= 32'(ONE_Q30);
          step_r    <= '0;
          state_r   <= F_MUL;
        end
        F_MUL: begin
          div_x_r <= mul_nxt;
          state_r <= F_DA;
        end
        F_FIN: begin
          s_r     <= s_nxt;
          c_r     <= c_nxt;
          state_r <= F_PUSH;
        end
        F_PUSH: if (!q_full) begin
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign busy = (state_r != F_IDLE);
  assign push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    push_data.rx   = item_r.rect_x;
    push_data.ry   = item_r.rect_y;
    push_data.w    = item_r.rect_width;
    push_data.h    = item_r.rect_height;
    push_data.dx   = -$signed({item_r.pivot_x[COORD_WIDTH-1], item_r.pivot_x});
    push_data.dy   = -$signed({item_r.pivot_y[COORD_WIDTH-1], item_r.pivot_y});
    push_data.rgba = item_r.fill_rgba;
    push_data.rot  = rot_r;
    push_data.s    = s_r;
    push_data.c    = c_r;
  end

endmodule

@@ hw/rtl/rrvg_queue.sv @@
// Two-entry queue between front end and vertex back end.
// Depends on rrvg_pkg for the entry type.
module rrvg_queue import rrvg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output q_entry_t head
);

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");

endmodule

@@ hw/rtl/rrvg_back.sv @@
// Back end: walks six vertices per queued rectangle through a two-stage rotate pipeline.
// Depends on rrvg_pkg; reads the head of rrvg_queue.
module rrvg_back import rrvg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int PW = OFS_WIDTH + TRIG_BITS;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXC = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINC = -(SW'(1) <<< (COORD_WIDTH - 1));

  vidx_t   idx_r;
  corner_t k;
  ofs_t    ox, oy;
  logic    issue;

  assign issue = !empty;
  assign pop   = issue && (idx_r == LAST_IDX);

  always_comb begin
    k  = corner_of(idx_r);
    ox = OFS_WIDTH'(head.dx) + (k[0] ? OFS_WIDTH'(head.w) : '0);
    oy = OFS_WIDTH'(head.dy) + (k[1] ? OFS_WIDTH'(head.h) : '0);
  end

  // stage 1: products
  logic                  s1_valid_r, s1_rot_r;
  vidx_t                 s1_idx_r;
  logic [RGBA_WIDTH-1:0] s1_rgba_r;
  coord_t                s1_rx_r, s1_ry_r;
  ofs_t                  s1_ox_r, s1_oy_r;
  logic signed [PW-1:0]  p_xc_r, p_ys_r, p_xs_r, p_yc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      s1_valid_r <= issue;
      if (issue) idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= idx_r;
    s1_rot_r  <= head.rot;
    s1_rgba_r <= head.rgba;
    s1_rx_r   <= head.rx;
    s1_ry_r   <= head.ry;
    s1_ox_r   <= ox;
    s1_oy_r   <= oy;
    p_xc_r    <= PW'(ox) * PW'(head.c);
    p_ys_r    <= PW'(oy) * PW'(head.s);
    p_xs_r    <= PW'(ox) * PW'(head.s);
    p_yc_r    <= PW'(oy) * PW'(head.c);
  end

  // stage 2: round, offset, saturate
  function automatic coord_t sat(input logic signed [SW-1:0] v);
    if (v > MAXC)      return MAXC[COORD_WIDTH-1:0];
    else if (v < MINC) return MINC[COORD_WIDTH-1:0];
    else               return v[COORD_WIDTH-1:0];
  endfunction

  logic signed [SW-1:0] rot_x, rot_y, vx, vy;
  always_comb begin
    rot_x = ((SW'(p_xc_r) - SW'(p_ys_r)) + (SW'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    rot_y = ((SW'(p_xs_r) + SW'(p_yc_r)) + (SW'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    vx = SW'(s1_rx_r) + (s1_rot_r ? rot_x : SW'(s1_ox_r));
    vy = SW'(s1_ry_r) + (s1_rot_r ? rot_y : SW'(s1_oy_r));
  end

  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    out_item_r.vert_x     <= sat(vx);
    out_item_r.vert_y     <= sat(vy);
    out_item_r.vert_rgba  <= s1_rgba_r;
    out_item_r.vert_index <= s1_idx_r;
    out_item_r.is_last    <= (s1_idx_r == LAST_IDX);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_item_r.vert_index != LAST_IDX |=>
      out_valid_r && out_item_r.vert_index == $past(out_item_r.vert_index) + 3'd1)
    else $error("vertex run broken");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_item_r.is_last |-> out_item_r.vert_index == LAST_IDX)
    else $error("last mark on wrong vertex");

endmodule
